[src/alm_pkg.sv]
`timescale 1ns / 1ps

package alm_pkg;

  localparam int SAMPLE_BITS  = 24;
  localparam int SQ_BITS      = 2 * SAMPLE_BITS;
  localparam int SUM_BITS     = 63;
  localparam int CNT_BITS     = 17;
  localparam int MAX_BLOCK    = 65536;
  localparam int DB_FRAC_BITS = 4;
  localparam int DB_BITS      = 12;
  localparam int LOG_FRAC     = 16;
  localparam int TOP_BITS     = 6;
  localparam int LG_BITS      = TOP_BITS + LOG_FRAC;
  localparam int MANT_BITS    = 32;
  localparam int K_BITS       = 18;
  localparam int SCALED_BITS  = LG_BITS + K_BITS;
  localparam int DIV_CNT_BITS = 6;

  localparam logic [SUM_BITS-1:0]     SUM_MAX      = {SUM_BITS{1'b1}};
  localparam logic [CNT_BITS-1:0]     BLOCK_LIMIT  = CNT_BITS'(MAX_BLOCK);
  localparam logic [DIV_CNT_BITS-1:0] DIV_LAST     = DIV_CNT_BITS'(SUM_BITS - 1);
  localparam logic [TOP_BITS-1:0]     TOP_START    = TOP_BITS'(SUM_BITS - 1);
  localparam logic [3:0]              ROUND_LAST   = 4'(LOG_FRAC - 1);
  localparam logic [LG_BITS-1:0]      LOG_REF      = LG_BITS'((2 * (SAMPLE_BITS - 1)) << LOG_FRAC);
  localparam logic [K_BITS-1:0]       TEN_LOG10_2  = K_BITS'(197283);
  localparam logic [SCALED_BITS:0]    ROUND_HALF   = (SCALED_BITS + 1)'(1) << (31 - DB_FRAC_BITS);
  localparam logic [DB_BITS-1:0]      FLOOR_MAG    = DB_BITS'(80 << DB_FRAC_BITS);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_DIV_INIT,
    ST_DIV,
    ST_LOAD_RMS,
    ST_LOAD_PEAK,
    ST_NORM,
    ST_ROUND,
    ST_SCALE,
    ST_FINISH,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load_sample;
    logic square;
    logic accum;
    logic div_init;
    logic div_step;
    logic load_rms;
    logic load_peak;
    logic norm_shift;
    logic round_init;
    logic round_step;
    logic scale;
    logic finish;
    logic dst_peak;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic div_last;
    logic norm_zero;
    logic norm_msb;
    logic round_last;
    logic out_busy;
  } stat_t;

endpackage

[src/alm_dp.sv]
`timescale 1ns / 1ps

module alm_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  alm_pkg::cmd_t                          cmd,
  output alm_pkg::stat_t                         stat,
  input  logic signed [alm_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                                   last,
  output logic signed [alm_pkg::DB_BITS-1:0]     rms_db,
  output logic signed [alm_pkg::DB_BITS-1:0]     peak_db,
  output logic                                   result_valid,
  input  logic                                   result_ready
);

  logic [alm_pkg::SAMPLE_BITS-1:0]   mag;
  logic [alm_pkg::SAMPLE_BITS-1:0]   mag_r;
  logic                              last_r;
  logic [alm_pkg::SQ_BITS-1:0]       sq;
  logic [alm_pkg::SUM_BITS-1:0]      square_sum;
  logic [alm_pkg::CNT_BITS-1:0]      sample_count;
  logic [alm_pkg::SAMPLE_BITS-1:0]   peak_magnitude;
  logic [alm_pkg::SUM_BITS-1:0]      dq;
  logic [alm_pkg::CNT_BITS-1:0]      rem;
  logic [alm_pkg::DIV_CNT_BITS-1:0]  div_cnt;
  logic [alm_pkg::SUM_BITS-1:0]      norm;
  logic [alm_pkg::TOP_BITS-1:0]      top;
  logic [alm_pkg::MANT_BITS-1:0]     m;
  logic [alm_pkg::LOG_FRAC-1:0]      frac;
  logic [3:0]                        rcnt;
  logic [alm_pkg::SCALED_BITS-1:0]   scaled;
  logic                              over_r;
  logic [alm_pkg::DB_BITS-1:0]       rms_r;

  logic [alm_pkg::MANT_BITS-1:0]     mul_op;
  logic [2*alm_pkg::MANT_BITS-1:0]   product;
  logic [alm_pkg::SUM_BITS:0]        sum_ext;
  logic [alm_pkg::CNT_BITS:0]        trial;
  logic [alm_pkg::CNT_BITS:0]        diff;
  logic                              q_bit;
  logic [alm_pkg::MANT_BITS:0]       sq_shift;
  logic [alm_pkg::LG_BITS-1:0]       lg;
  logic [alm_pkg::LG_BITS-1:0]       below;
  logic [alm_pkg::SCALED_BITS-1:0]   scale_prod;
  logic [alm_pkg::SCALED_BITS:0]     round_sum;
  logic [12:0]                       rnd;
  logic [alm_pkg::DB_BITS-1:0]       mag_db;
  logic [alm_pkg::DB_BITS-1:0]       level;

  // Take the magnitude; the most negative code maps to full scale
  assign mag = sample[alm_pkg::SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;

  // Share one squaring multiplier among sample, peak and log rounds
  always_comb begin
    priority if (cmd.round_step) begin
      mul_op = m;
    end else if (cmd.load_peak) begin
      mul_op = alm_pkg::MANT_BITS'(peak_magnitude);
    end else begin
      mul_op = alm_pkg::MANT_BITS'(mag_r);
    end
  end
  assign product = mul_op * mul_op;

  assign sum_ext = {1'b0, square_sum} + (alm_pkg::SUM_BITS + 1)'(sq);

  // Restoring division step
  assign trial = {rem, dq[alm_pkg::SUM_BITS-1]};
  assign q_bit = trial >= {1'b0, sample_count};
  assign diff  = trial - {1'b0, sample_count};

  assign sq_shift = product[2*alm_pkg::MANT_BITS-1:alm_pkg::MANT_BITS-1];

  // Scale log2 distance below full scale to dB, then round and clamp
  assign lg         = {top, frac};
  assign below      = alm_pkg::LOG_REF - lg;
  assign scale_prod = below * alm_pkg::TEN_LOG10_2;
  assign round_sum  = {1'b0, scaled} + alm_pkg::ROUND_HALF;
  assign rnd        = round_sum[alm_pkg::SCALED_BITS:alm_pkg::SCALED_BITS-12];
  assign mag_db     = (rnd > 13'(alm_pkg::FLOOR_MAG)) ? alm_pkg::FLOOR_MAG
                                                      : alm_pkg::DB_BITS'(rnd);

  always_comb begin
    priority if (norm == '0) begin
      level = alm_pkg::DB_BITS'(0) - alm_pkg::FLOOR_MAG;
    end else if (over_r) begin
      level = '0;
    end else begin
      level = alm_pkg::DB_BITS'(0) - mag_db;
    end
  end

  // Accumulators and result handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum     <= '0;
      sample_count   <= '0;
      peak_magnitude <= '0;
      result_valid   <= 1'b0;
    end else begin
      if (cmd.square && (mag_r > peak_magnitude)) begin
        peak_magnitude <= mag_r;
      end
      if (cmd.accum && (sample_count < alm_pkg::BLOCK_LIMIT)) begin
        square_sum   <= sum_ext[alm_pkg::SUM_BITS] ? alm_pkg::SUM_MAX
                                                   : sum_ext[alm_pkg::SUM_BITS-1:0];
        sample_count <= sample_count + 1'b1;
      end
      if (cmd.emit) begin
        square_sum     <= '0;
        sample_count   <= '0;
        peak_magnitude <= '0;
        result_valid   <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load_sample) begin
      mag_r  <= mag;
      last_r <= last;
    end
    if (cmd.square) begin
      sq <= product[alm_pkg::SQ_BITS-1:0];
    end
    if (cmd.div_init) begin
      dq      <= square_sum;
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      dq      <= {dq[alm_pkg::SUM_BITS-2:0], q_bit};
      rem     <= q_bit ? diff[alm_pkg::CNT_BITS-1:0] : trial[alm_pkg::CNT_BITS-1:0];
      div_cnt <= div_cnt + 1'b1;
    end
    if (cmd.load_rms) begin
      norm <= dq;
      top  <= alm_pkg::TOP_START;
    end else if (cmd.load_peak) begin
      norm <= alm_pkg::SUM_BITS'(product[alm_pkg::SQ_BITS-1:0]);
      top  <= alm_pkg::TOP_START;
    end else if (cmd.norm_shift) begin
      norm <= {norm[alm_pkg::SUM_BITS-2:0], 1'b0};
      top  <= top - 1'b1;
    end
    if (cmd.round_init) begin
      m    <= norm[alm_pkg::SUM_BITS-1:alm_pkg::SUM_BITS-alm_pkg::MANT_BITS];
      frac <= '0;
      rcnt <= '0;
    end else if (cmd.round_step) begin
      m    <= sq_shift[alm_pkg::MANT_BITS] ? sq_shift[alm_pkg::MANT_BITS:1]
                                           : sq_shift[alm_pkg::MANT_BITS-1:0];
      frac <= {frac[alm_pkg::LOG_FRAC-2:0], sq_shift[alm_pkg::MANT_BITS]};
      rcnt <= rcnt + 1'b1;
    end
    if (cmd.scale) begin
      scaled <= scale_prod;
      over_r <= lg >= alm_pkg::LOG_REF;
    end
    if (cmd.finish && !cmd.dst_peak) begin
      rms_r <= level;
    end
    if (cmd.emit) begin
      rms_db  <= rms_r;
      peak_db <= level;
    end
  end

  // Status back to the controller
  always_comb begin
    stat.last       = last_r;
    stat.div_last   = div_cnt == alm_pkg::DIV_LAST;
    stat.norm_zero  = norm == '0;
    stat.norm_msb   = norm[alm_pkg::SUM_BITS-1];
    stat.round_last = rcnt == alm_pkg::ROUND_LAST;
    stat.out_busy   = result_valid;
  end

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    sample_count <= alm_pkg::BLOCK_LIMIT)
    else $error("sample count beyond block limit");

  a_clear_after_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (square_sum == '0) && (sample_count == '0) && (peak_magnitude == '0))
    else $error("accumulators not cleared after result");

  a_emit_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !result_valid)
    else $error("result overwritten before transfer");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (rms_db <= 0) && (rms_db >= -1280) && (peak_db <= 0) && (peak_db >= -1280))
    else $error("level out of range");

endmodule

[src/alm_ctrl.sv]
`timescale 1ns / 1ps

module alm_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           sample_valid,
  output logic           sample_ready,
  input  alm_pkg::stat_t stat,
  output alm_pkg::cmd_t  cmd
);

  alm_pkg::state_t state;
  alm_pkg::state_t state_next;
  logic            pass_peak;

  // Hold state and track which level the log pass is for
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= alm_pkg::ST_IDLE;
      pass_peak <= 1'b0;
    end else begin
      state <= state_next;
      if (state == alm_pkg::ST_LOAD_RMS) begin
        pass_peak <= 1'b0;
      end else if (state == alm_pkg::ST_LOAD_PEAK) begin
        pass_peak <= 1'b1;
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      alm_pkg::ST_IDLE: begin
        if (sample_valid) state_next = alm_pkg::ST_SQUARE;
      end
      alm_pkg::ST_SQUARE:    state_next = alm_pkg::ST_ACCUM;
      alm_pkg::ST_ACCUM: begin
        state_next = stat.last ? alm_pkg::ST_DIV_INIT : alm_pkg::ST_IDLE;
      end
      alm_pkg::ST_DIV_INIT:  state_next = alm_pkg::ST_DIV;
      alm_pkg::ST_DIV: begin
        if (stat.div_last) state_next = alm_pkg::ST_LOAD_RMS;
      end
      alm_pkg::ST_LOAD_RMS:  state_next = alm_pkg::ST_NORM;
      alm_pkg::ST_LOAD_PEAK: state_next = alm_pkg::ST_NORM;
      alm_pkg::ST_NORM: begin
        priority if (stat.norm_zero) begin
          state_next = alm_pkg::ST_FINISH;
        end else if (stat.norm_msb) begin
          state_next = alm_pkg::ST_ROUND;
        end
      end
      alm_pkg::ST_ROUND: begin
        if (stat.round_last) state_next = alm_pkg::ST_SCALE;
      end
      alm_pkg::ST_SCALE:     state_next = alm_pkg::ST_FINISH;
      alm_pkg::ST_FINISH: begin
        state_next = pass_peak ? alm_pkg::ST_EMIT : alm_pkg::ST_LOAD_PEAK;
      end
      alm_pkg::ST_EMIT: begin
        if (!stat.out_busy) state_next = alm_pkg::ST_IDLE;
      end
      default:               state_next = alm_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd          = '0;
    sample_ready = 1'b0;
    cmd.dst_peak = pass_peak;
    unique case (state)
      alm_pkg::ST_IDLE: begin
        sample_ready    = 1'b1;
        cmd.load_sample = sample_valid;
      end
      alm_pkg::ST_SQUARE:    cmd.square    = 1'b1;
      alm_pkg::ST_ACCUM:     cmd.accum     = 1'b1;
      alm_pkg::ST_DIV_INIT:  cmd.div_init  = 1'b1;
      alm_pkg::ST_DIV:       cmd.div_step  = 1'b1;
      alm_pkg::ST_LOAD_RMS:  cmd.load_rms  = 1'b1;
      alm_pkg::ST_LOAD_PEAK: cmd.load_peak = 1'b1;
      alm_pkg::ST_NORM: begin
        cmd.round_init = !stat.norm_zero && stat.norm_msb;
        cmd.norm_shift = !stat.norm_zero && !stat.norm_msb;
      end
      alm_pkg::ST_ROUND:     cmd.round_step = 1'b1;
      alm_pkg::ST_SCALE:     cmd.scale      = 1'b1;
      alm_pkg::ST_FINISH:    cmd.finish     = 1'b1;
      alm_pkg::ST_EMIT:      cmd.emit       = !stat.out_busy;
      default: begin
      end
    endcase
  end

  a_ready_idle_only: assert property (@(posedge clk) disable iff (rst)
    sample_ready |-> (state == alm_pkg::ST_IDLE))
    else $error("input taken outside idle");

  a_peak_after_rms: assert property (@(posedge clk) disable iff (rst)
    (state == alm_pkg::ST_EMIT) |-> pass_peak)
    else $error("result emitted before peak pass");

  a_accept_to_square: assert property (@(posedge clk) disable iff (rst)
    cmd.load_sample |=> (state == alm_pkg::ST_SQUARE))
    else $error("accepted sample not squared");

endmodule

[src/audio_level_meter_db_top.sv]
`timescale 1ns / 1ps

// RMS and peak level meter. Feed the signed samples of one buffer, all
// channels interleaved, and flag the final one with last; after it one
// result carries the RMS and peak levels in dBFS, units of 1/16 dB,
// clamped to -80..0 dB (a silent buffer reads -80 dB). Each sample is
// accepted, squared and accumulated before the next one is taken.
// After the last sample's accumulate come a setup step and 63 division
// steps for the mean square, one quotient bit each, then two log passes,
// first RMS then peak. A pass loads its value, shifts it left until the
// top bit is set (16 to 62 normalizing shifts), sets up and runs 16
// squaring rounds on the shared 32x32 multiplier, then scales and
// finishes; a zero value goes straight from normalizing to finish. An
// emit step follows, which waits while the previous result still waits
// for transfer. A finished result sits in its own register, so new samples
// are taken while it waits for transfer.
module audio_level_meter_db_top (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   sample_valid,
  output logic                                   sample_ready,
  input  logic signed [alm_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                                   last,
  output logic                                   result_valid,
  input  logic                                   result_ready,
  output logic signed [alm_pkg::DB_BITS-1:0]     rms_db,
  output logic signed [alm_pkg::DB_BITS-1:0]     peak_db
);

  alm_pkg::cmd_t  cmd;
  alm_pkg::stat_t stat;

  alm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  alm_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .sample       (sample),
    .last         (last),
    .rms_db       (rms_db),
    .peak_db      (peak_db),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

endmodule
